>>> hdl/b32h_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the base32hex decoder
package b32h_pkg;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_BAD  = 2'd1;
   localparam logic [1:0] STATUS_SIZE = 2'd2;

   // the five legal pad layouts of a group, bit i is position i
   localparam logic [7:0] PADS_NONE  = 8'b0000_0000;
   localparam logic [7:0] PADS_ONE   = 8'b1000_0000;
   localparam logic [7:0] PADS_THREE = 8'b1110_0000;
   localparam logic [7:0] PADS_FOUR  = 8'b1111_0000;
   localparam logic [7:0] PADS_SIX   = 8'b1111_1100;

   // characters with a meaning of their own
   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // what the back end has to do for one queued job
   typedef enum logic [1:0] {
      JOB_DATA,
      JOB_BAD,
      JOB_SHORT
   } job_kind_type;

   // one job: a decoded group or an error report
   typedef struct packed {
      job_kind_type kind;
      logic [39:0]  bits;   // group bits, first character in the top bits
      logic [2:0]   count;  // number of results, 1 to 5
      logic         last;   // group closes the stream
   } job_type;

endpackage

>>> hdl/b32h_front.sv
`timescale 1ns / 1ps
// front end: maps characters, collects groups of eight and checks padding
module b32h_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [7:0]      char_code,
   input  logic            stream_last,
   input  logic            queue_full,
   output logic            push,
   output b32h_pkg::job_type push_job
);
   import b32h_pkg::*;

   logic [2:0] pos_ff, pos_in;
   logic       hold_ff, hold_in;
   logic [4:0] val_ff [0:6];
   logic [6:0] pad_ff;
   logic [6:0] bad_ff;

   logic       accept;
   logic [4:0] cur_val;
   logic       cur_pad;
   logic       cur_bad;
   logic [7:0] pad_vec;
   logic       any_bad;
   logic [2:0] nbytes;
   logic       layout_ok;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;

   // character map: symbol value, pad mark, bad mark
   always_comb begin
      cur_val = 5'd0;
      cur_pad = 1'b0;
      cur_bad = 1'b0;
      if (char_code >= 8'h30 && char_code <= 8'h39) begin
         cur_val = 5'(char_code - 8'h30);
      end else if (char_code >= 8'h41 && char_code <= 8'h56) begin
         cur_val = 5'(char_code - 8'h41 + 8'd10);
      end else if (char_code >= 8'h61 && char_code <= 8'h76) begin
         cur_val = 5'(char_code - 8'h61 + 8'd10);
      end else if (char_code == CHAR_PAD) begin
         cur_pad = 1'b1;
      end else begin
         cur_bad = 1'b1;
      end
   end

   // group check on the eighth character
   assign pad_vec = {cur_pad, pad_ff};
   assign any_bad = cur_bad || (|bad_ff);

   always_comb begin
      layout_ok = 1'b1;
      nbytes    = 3'd5;
      unique case (pad_vec)
         PADS_NONE:  nbytes = 3'd5;
         PADS_ONE:   nbytes = 3'd4;
         PADS_THREE: nbytes = 3'd3;
         PADS_FOUR:  nbytes = 3'd2;
         PADS_SIX:   nbytes = 3'd1;
         default:    layout_ok = 1'b0;
      endcase
   end

   // job build, group position and error hold
   always_comb begin
      pos_in         = pos_ff;
      hold_in        = hold_ff;
      push           = 1'b0;
      push_job.kind  = JOB_DATA;
      push_job.bits  = {val_ff[0], val_ff[1], val_ff[2], val_ff[3],
                        val_ff[4], val_ff[5], val_ff[6], cur_val};
      push_job.count = nbytes;
      push_job.last  = stream_last;
      if (accept) begin
         if (hold_ff) begin
            if (stream_last) begin
               hold_in = 1'b0;
               pos_in  = 3'd0;
            end
         end else if (pos_ff != 3'd7) begin
            if (stream_last) begin
               push           = 1'b1;
               push_job.kind  = JOB_SHORT;
               push_job.count = 3'd1;
               pos_in         = 3'd0;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end else begin
            push   = 1'b1;
            pos_in = 3'd0;
            if (any_bad || !layout_ok) begin
               push_job.kind  = JOB_BAD;
               push_job.count = 3'd1;
               hold_in        = !stream_last;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 3'd0;
         hold_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         hold_ff <= hold_in;
      end
   end

   // group storage for the first seven characters
   always_ff @(posedge clock) begin
      if (accept && !hold_ff && pos_ff != 3'd7) begin
         val_ff[pos_ff] <= cur_val;
         pad_ff[pos_ff] <= cur_pad;
         bad_ff[pos_ff] <= cur_bad;
      end
   end

endmodule

>>> hdl/b32h_queue.sv
`timescale 1ns / 1ps
// short job queue between the front end and the back end
module b32h_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b32h_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output b32h_pkg::job_type pop_job
);
   import b32h_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_job   = slot_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/b32h_back.sv
`timescale 1ns / 1ps
// back end: turns a job into results, one per cycle into a free output register
module b32h_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  b32h_pkg::job_type job,
   output logic              pop,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [7:0]        out_byte,
   output logic              byte_valid,
   output logic [1:0]        status,
   output logic              run_end,
   output logic              stream_end
);
   import b32h_pkg::*;

   job_type    cur_ff;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, bval_in;
   logic [1:0] status_ff, status_in;
   logic       rend_ff, rend_in;
   logic       send_ff, send_in;

   logic       out_free;
   logic       fire;
   logic       fin;
   logic [7:0] sel_byte;

   assign out_free = !valid_ff || out_ready;
   assign fire     = busy_ff && out_free;
   assign fin      = (idx_ff == cur_ff.count - 3'd1);
   assign pop      = job_valid && (!busy_ff || (fire && fin));

   // byte select within the group
   always_comb begin
      case (idx_ff)
         3'd0:    sel_byte = cur_ff.bits[39:32];
         3'd1:    sel_byte = cur_ff.bits[31:24];
         3'd2:    sel_byte = cur_ff.bits[23:16];
         3'd3:    sel_byte = cur_ff.bits[15:8];
         default: sel_byte = cur_ff.bits[7:0];
      endcase
   end

   // result build and sequencing
   always_comb begin
      busy_in   = busy_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !out_ready;
      byte_in   = byte_ff;
      bval_in   = bval_ff;
      status_in = status_ff;
      rend_in   = rend_ff;
      send_in   = send_ff;
      if (fire) begin
         valid_in = 1'b1;
         rend_in  = fin;
         unique case (cur_ff.kind)
            JOB_DATA: begin
               byte_in   = sel_byte;
               bval_in   = 1'b1;
               status_in = STATUS_OK;
               send_in   = fin && cur_ff.last;
            end
            JOB_BAD: begin
               byte_in   = 8'd0;
               bval_in   = 1'b0;
               status_in = STATUS_BAD;
               send_in   = 1'b1;
            end
            default: begin
               byte_in   = 8'd0;
               bval_in   = 1'b0;
               status_in = STATUS_SIZE;
               send_in   = 1'b1;
            end
         endcase
         idx_in = idx_ff + 3'd1;
         if (fin) begin
            busy_in = 1'b0;
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= job;
      end
      byte_ff   <= byte_in;
      bval_ff   <= bval_in;
      status_ff <= status_in;
      rend_ff   <= rend_in;
      send_ff   <= send_in;
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign byte_valid = bval_ff;
   assign status     = status_ff;
   assign run_end    = rend_ff;
   assign stream_end = send_ff;

endmodule

>>> hdl/base32hex_decoder_top.sv
`timescale 1ns / 1ps
// top level of the streaming base32hex decoder
//
// req channel: one text character per item in req_tdata, req_tlast on the
// final character of the encoded text. rsp channel: one decoded byte or one
// status report per item, rsp_tlast when the item closes the stream or
// reports an error. Groups of eight characters decode to 1 to 5 bytes.
// Throughput: one character per cycle while the job queue is not full; a
// group's bytes leave one per cycle while the output register is free.
// After its eighth character is accepted, the first result of a group
// passes a job queue slot, then the back end job register, then the
// output register, which raises rsp_tvalid.
// The front end stalls only when the job queue is full, which happens when
// the receiver holds rsp_tready low; the output register keeps its item
// stable until it is taken.
// After a bad character or bad padding the rest of the stream is dropped
// up to and including the item with req_tlast.
// Reset (synchronous, active high) empties the queue, drops any partial
// group and clears the error hold; no clearing pass is needed.
module base32hex_decoder_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // stream_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [3:0] rsp_tuser,   // [0] byte_valid, [2:1] status, [3] run_end
   output logic       rsp_tlast    // stream_end
);
   import b32h_pkg::*;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    pop_valid;
   job_type pop_job;
   logic    byte_valid;
   logic [1:0] status;
   logic    run_end;

   // character intake and group check
   b32h_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .char_code   (req_tdata),
      .stream_last (req_tlast),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   // job queue
   b32h_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_job   (pop_job)
   );

   // result output
   b32h_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .byte_valid (byte_valid),
      .status     (status),
      .run_end    (run_end),
      .stream_end (rsp_tlast)
   );

   assign rsp_tuser = {run_end, status, byte_valid};

endmodule
